[sv/ciou_pkg.sv]
package ciou_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_TABLE_LEN = 24;

    // atan(2^-i) in Q30 radians, truncated
    localparam logic [31:0] ATAN_Q30 [ATAN_TABLE_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    localparam logic [28:0] FOUR_OVER_PI2_Q30 = 29'd435171170;
    localparam logic [26:0] ONE_Q24 = 27'h1000000;
    localparam logic [27:0] DIST_CAP_Q24 = 28'h8000000;

    localparam int IOU_QBITS = 25;
    localparam int DIST_QBITS = 27;
    localparam int ASP_QBITS = 25;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [15:0] pred_x1;
        logic signed [15:0] pred_y1;
        logic signed [15:0] pred_x2;
        logic signed [15:0] pred_y2;
        logic signed [15:0] tgt_x1;
        logic signed [15:0] tgt_y1;
        logic signed [15:0] tgt_x2;
        logic signed [15:0] tgt_y2;
    } ciou_in_t;

    typedef struct packed {
        logic [15:0]        overlap_ratio;
        logic signed [15:0] complete_ratio;
    } ciou_out_t;

    // box geometry handed from the front to the back
    typedef struct packed {
        logic [15:0]        iw;
        logic [15:0]        ih;
        logic [15:0]        pw;
        logic [15:0]        ph;
        logic [15:0]        tw;
        logic [15:0]        th;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic signed [16:0] cw;
        logic signed [16:0] ch;
    } ciou_geom_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ciou_qstat_t;

endpackage

[sv/ciou_front.sv]
module ciou_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  ciou_pkg::ciou_in_t     boxes,
    input  ciou_pkg::ciou_qstat_t  q_stat,
    output logic                   fwd_valid,
    output ciou_pkg::ciou_geom_t   fwd_geom
);
    import ciou_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    ciou_geom_t geom_reg;
    ciou_geom_t geom_next;
    logic       accept;
    logic       moved;

    logic signed [15:0] ix1, ix2, iy1, iy2, ex1, ex2, ey1, ey2;
    logic signed [16:0] pw_d, ph_d, tw_d, th_d, iw_d, ih_d;

    assign full   = valid_reg && q_stat.full;
    assign accept = push && !full;
    assign moved  = valid_reg && !q_stat.full;

    always_comb
    begin
        ix1 = (boxes.pred_x1 > boxes.tgt_x1) ? boxes.pred_x1 : boxes.tgt_x1;
        iy1 = (boxes.pred_y1 > boxes.tgt_y1) ? boxes.pred_y1 : boxes.tgt_y1;
        ix2 = (boxes.pred_x2 < boxes.tgt_x2) ? boxes.pred_x2 : boxes.tgt_x2;
        iy2 = (boxes.pred_y2 < boxes.tgt_y2) ? boxes.pred_y2 : boxes.tgt_y2;
        ex1 = (boxes.pred_x1 < boxes.tgt_x1) ? boxes.pred_x1 : boxes.tgt_x1;
        ey1 = (boxes.pred_y1 < boxes.tgt_y1) ? boxes.pred_y1 : boxes.tgt_y1;
        ex2 = (boxes.pred_x2 > boxes.tgt_x2) ? boxes.pred_x2 : boxes.tgt_x2;
        ey2 = (boxes.pred_y2 > boxes.tgt_y2) ? boxes.pred_y2 : boxes.tgt_y2;

        iw_d = 17'(ix2) - 17'(ix1);
        ih_d = 17'(iy2) - 17'(iy1);
        pw_d = 17'(boxes.pred_x2) - 17'(boxes.pred_x1);
        ph_d = 17'(boxes.pred_y2) - 17'(boxes.pred_y1);
        tw_d = 17'(boxes.tgt_x2) - 17'(boxes.tgt_x1);
        th_d = 17'(boxes.tgt_y2) - 17'(boxes.tgt_y1);

        // inverted extents count as zero
        geom_next.iw = iw_d[16] ? 16'd0 : iw_d[15:0];
        geom_next.ih = ih_d[16] ? 16'd0 : ih_d[15:0];
        geom_next.pw = pw_d[16] ? 16'd0 : pw_d[15:0];
        geom_next.ph = ph_d[16] ? 16'd0 : ph_d[15:0];
        geom_next.tw = tw_d[16] ? 16'd0 : tw_d[15:0];
        geom_next.th = th_d[16] ? 16'd0 : th_d[15:0];
        geom_next.dx = (18'(boxes.pred_x1) + 18'(boxes.pred_x2))
                     - (18'(boxes.tgt_x1) + 18'(boxes.tgt_x2));
        geom_next.dy = (18'(boxes.pred_y1) + 18'(boxes.pred_y2))
                     - (18'(boxes.tgt_y1) + 18'(boxes.tgt_y2));
        geom_next.cw = 17'(ex2) - 17'(ex1);
        geom_next.ch = 17'(ey2) - 17'(ey1);

        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (moved)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            geom_reg <= geom_next;
        end
    end

    assign fwd_valid = moved;
    assign fwd_geom  = geom_reg;

endmodule

[sv/ciou_queue.sv]
module ciou_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  ciou_pkg::ciou_geom_t  wr_data,
    input  logic                  rd_en,
    output ciou_pkg::ciou_geom_t  rd_data,
    output ciou_pkg::ciou_qstat_t stat
);
    import ciou_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    ciou_geom_t      entry_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + (AW+1)'(1);
                2'b01:   count_reg <= count_reg - (AW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign rd_data    = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

[sv/ciou_delay.sv]
module ciou_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

[sv/ciou_div.sv]
module ciou_div #(
    parameter int DW = 33,
    parameter int NB = 25
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [NB-1:0] low_in,
    input  logic [DW-1:0] dvs_in,
    output logic [NB-1:0] quo
);

    logic [DW-1:0] rem_reg [NB];
    logic [NB-1:0] low_reg [NB];
    logic [DW-1:0] dvs_reg [NB];
    logic [NB-1:0] quo_reg [NB];

    genvar k;
    generate
        for (k = 0; k < NB; k++)
        begin : g_step
            logic [DW-1:0] rem_prev;
            logic [DW-1:0] dvs_prev;
            logic [NB-1:0] low_prev;
            logic [NB-1:0] quo_prev;
            logic [DW:0]   trial;
            logic [DW:0]   rest;
            logic          hit;

            if (k == 0)
            begin : g_first
                assign rem_prev = rem_in;
                assign dvs_prev = dvs_in;
                assign low_prev = low_in;
                assign quo_prev = '0;
            end
            else
            begin : g_next
                assign rem_prev = rem_reg[k-1];
                assign dvs_prev = dvs_reg[k-1];
                assign low_prev = low_reg[k-1];
                assign quo_prev = quo_reg[k-1];
            end

            // bring down one dividend bit, subtract when it fits
            assign trial = {rem_prev, low_prev[NB-1]};
            assign hit   = (trial >= {1'b0, dvs_prev});
            assign rest  = trial - {1'b0, dvs_prev};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= hit ? rest[DW-1:0] : trial[DW-1:0];
                    low_reg[k] <= {low_prev[NB-2:0], 1'b0};
                    dvs_reg[k] <= dvs_prev;
                    quo_reg[k] <= {quo_prev[NB-2:0], hit};
                end
            end
        end
    endgenerate

    assign quo = quo_reg[NB-1];

endmodule

[sv/ciou_cordic.sv]
module ciou_cordic #(
    parameter int STEPS = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        num,
    input  logic [15:0]        den,
    output logic signed [32:0] angle
);
    import ciou_pkg::*;

    localparam int XW = 34;

    logic signed [XW-1:0] x_reg [STEPS];
    logic signed [XW-1:0] y_reg [STEPS];
    logic signed [32:0]   z_reg [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_rot
            logic signed [XW-1:0] x_prev;
            logic signed [XW-1:0] y_prev;
            logic signed [32:0]   z_prev;
            logic signed [XW-1:0] xs;
            logic signed [XW-1:0] ys;
            logic signed [32:0]   step_ang;

            if (k == 0)
            begin : g_first
                assign x_prev = $signed({4'b0, den, 14'd0});
                assign y_prev = $signed({4'b0, num, 14'd0});
                assign z_prev = '0;
            end
            else
            begin : g_next
                assign x_prev = x_reg[k-1];
                assign y_prev = y_reg[k-1];
                assign z_prev = z_reg[k-1];
            end

            assign xs       = x_prev >>> k;
            assign ys       = y_prev >>> k;
            assign step_ang = $signed({1'b0, ATAN_Q30[k]});

            // rotate toward the x axis, accumulate the angle
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!y_prev[XW-1])
                    begin
                        x_reg[k] <= x_prev + ys;
                        y_reg[k] <= y_prev - xs;
                        z_reg[k] <= z_prev + step_ang;
                    end
                    else
                    begin
                        x_reg[k] <= x_prev - ys;
                        y_reg[k] <= y_prev + xs;
                        z_reg[k] <= z_prev - step_ang;
                    end
                end
            end
        end
    endgenerate

    assign angle = z_reg[STEPS-1];

endmodule

[sv/ciou_back.sv]
module ciou_back #(
    parameter int CORDIC_STEPS = ciou_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ciou_pkg::ciou_qstat_t q_stat,
    input  ciou_pkg::ciou_geom_t  head,
    output logic                  take,
    output logic                  empty,
    input  logic                  pop,
    output ciou_pkg::ciou_out_t   ratios
);
    import ciou_pkg::*;

    localparam int N       = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS : ATAN_TABLE_LEN;
    localparam int ST_DIV  = 2;
    localparam int ST_FLAG = 3;
    localparam int ST_IOU  = ST_DIV + IOU_QBITS + 1;
    localparam int ST_DIST = ST_DIV + DIST_QBITS + 1;
    localparam int ST_V    = N + 5;
    localparam int ST_DEN  = ((ST_IOU > ST_V) ? ST_IOU : ST_V) + 2;
    localparam int ST_TOT  = ST_DEN + ASP_QBITS + 1;
    localparam int ST_OUT  = ST_TOT + 1;

    logic              en;
    logic [ST_OUT:1]   vld_reg;

    // stage 1: products, clamped sides
    logic [31:0]        inter_full, areap_full, areat_full;
    logic signed [35:0] dxx_full, dyy_full;
    logic signed [33:0] cww_full, chh_full;
    logic [31:0]        inter1_reg, areap1_reg, areat1_reg, cww1_reg, chh1_reg;
    logic [33:0]        dxx1_reg, dyy1_reg;
    logic [15:0]        pw1_reg, ph1_reg, tw1_reg, th1_reg;

    // stage 2: sums
    logic [31:0]        inter2_reg;
    logic [32:0]        uni2_reg;
    logic [34:0]        s2_reg;
    logic [32:0]        c22_reg;

    // stage 3: special-case flags
    logic               uni_zero3_reg;
    logic [1:0]         dist_fl3_reg;

    logic [IOU_QBITS-1:0]  q_iou;
    logic [DIST_QBITS-1:0] q_dist;
    logic [ASP_QBITS-1:0]  q_asp;
    logic                  uni_zero_d;
    logic [1:0]            dist_fl_d;
    logic [24:0]           iou_reg;
    logic [27:0]           dist_reg;

    // aspect path
    logic signed [32:0]    z_tgt, z_pred;
    logic signed [33:0]    diff_reg;
    logic [31:0]           ad_reg;
    logic [63:0]           ad_sq;
    logic [25:0]           sq_reg;
    logic [54:0]           v_prod;
    logic [24:0]           v_reg;
    logic [24:0]           v_d;
    logic [24:0]           iou_den_d;
    logic [26:0]           den_full;
    logic [49:0]           vv_reg;
    logic [25:0]           den_reg;
    logic                  anz_reg;
    logic                  anz_d;

    logic [24:0]           iou_tot_d;
    logic [27:0]           dist_tot_d;
    logic signed [28:0]    tot_reg;
    logic [15:0]           ovl_reg;
    logic signed [18:0]    tot_sh;
    logic signed [15:0]    cplx_next;
    ciou_out_t             out_reg;

    // one enable for the whole pipe: advance unless a result is stuck
    assign en    = !vld_reg[ST_OUT] || pop;
    assign take  = en && !q_stat.empty;
    assign empty = !vld_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ST_OUT-1:1], take};
        end
    end

    assign inter_full = head.iw * head.ih;
    assign areap_full = head.pw * head.ph;
    assign areat_full = head.tw * head.th;
    assign dxx_full   = head.dx * head.dx;
    assign dyy_full   = head.dy * head.dy;
    assign cww_full   = head.cw * head.cw;
    assign chh_full   = head.ch * head.ch;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inter1_reg <= inter_full;
            areap1_reg <= areap_full;
            areat1_reg <= areat_full;
            dxx1_reg   <= dxx_full[33:0];
            dyy1_reg   <= dyy_full[33:0];
            cww1_reg   <= cww_full[31:0];
            chh1_reg   <= chh_full[31:0];
            pw1_reg    <= (head.pw == '0) ? 16'd1 : head.pw;
            ph1_reg    <= (head.ph == '0) ? 16'd1 : head.ph;
            tw1_reg    <= (head.tw == '0) ? 16'd1 : head.tw;
            th1_reg    <= (head.th == '0) ? 16'd1 : head.th;

            inter2_reg <= inter1_reg;
            uni2_reg   <= 33'(areap1_reg) + 33'(areat1_reg) - 33'(inter1_reg);
            s2_reg     <= 35'(dxx1_reg) + 35'(dyy1_reg);
            c22_reg    <= 33'(cww1_reg) + 33'(chh1_reg);

            uni_zero3_reg   <= (uni2_reg == '0);
            dist_fl3_reg[1] <= (c22_reg == '0);
            dist_fl3_reg[0] <= (38'(s2_reg) >= {c22_reg, 5'd0});
        end
    end

    // IoU = (inter << 24) / union
    ciou_div #(.DW(33), .NB(IOU_QBITS)) u_div_iou (
        .clk    (clk),
        .en     (en),
        .rem_in (33'(inter2_reg[31:1])),
        .low_in ({inter2_reg[0], 24'd0}),
        .dvs_in (uni2_reg),
        .quo    (q_iou)
    );

    // distance = (s << 22) / c^2
    ciou_div #(.DW(33), .NB(DIST_QBITS)) u_div_dist (
        .clk    (clk),
        .en     (en),
        .rem_in (33'(s2_reg[34:5])),
        .low_in ({s2_reg[4:0], 22'd0}),
        .dvs_in (c22_reg),
        .quo    (q_dist)
    );

    ciou_delay #(.WIDTH(1), .DEPTH(ST_IOU - 1 - ST_FLAG)) u_dly_uz (
        .clk (clk), .en (en), .d (uni_zero3_reg), .q (uni_zero_d)
    );

    ciou_delay #(.WIDTH(2), .DEPTH(ST_DIST - 1 - ST_FLAG)) u_dly_df (
        .clk (clk), .en (en), .d (dist_fl3_reg), .q (dist_fl_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            iou_reg <= uni_zero_d ? '0 : q_iou;
            if (dist_fl_d[1])
            begin
                dist_reg <= '0;
            end
            else if (dist_fl_d[0])
            begin
                dist_reg <= DIST_CAP_Q24;
            end
            else
            begin
                dist_reg <= {1'b0, q_dist};
            end
        end
    end

    ciou_cordic #(.STEPS(N)) u_cordic_tgt (
        .clk (clk), .en (en), .num (tw1_reg), .den (th1_reg), .angle (z_tgt)
    );

    ciou_cordic #(.STEPS(N)) u_cordic_pred (
        .clk (clk), .en (en), .num (pw1_reg), .den (ph1_reg), .angle (z_pred)
    );

    assign ad_sq  = ad_reg * ad_reg;
    assign v_prod = sq_reg * FOUR_OVER_PI2_Q30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= 34'(z_tgt) - 34'(z_pred);
            ad_reg   <= diff_reg[33] ? 32'(-diff_reg) : diff_reg[31:0];
            sq_reg   <= ad_sq[61:36];
            v_reg    <= v_prod[54:30];
        end
    end

    ciou_delay #(.WIDTH(25), .DEPTH(ST_DEN - 1 - ST_V)) u_dly_v (
        .clk (clk), .en (en), .d (v_reg), .q (v_d)
    );

    ciou_delay #(.WIDTH(25), .DEPTH(ST_DEN - 1 - ST_IOU)) u_dly_iou_den (
        .clk (clk), .en (en), .d (iou_reg), .q (iou_den_d)
    );

    assign den_full = 27'(v_d) + ONE_Q24 - 27'(iou_den_d);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vv_reg  <= v_d * v_d;
            den_reg <= den_full[25:0];
            anz_reg <= (v_d != '0);
        end
    end

    // alpha * v = v^2 / (v - iou + 1)
    ciou_div #(.DW(26), .NB(ASP_QBITS)) u_div_asp (
        .clk    (clk),
        .en     (en),
        .rem_in (26'(vv_reg[49:25])),
        .low_in (vv_reg[24:0]),
        .dvs_in (den_reg),
        .quo    (q_asp)
    );

    ciou_delay #(.WIDTH(1), .DEPTH(ST_TOT - 1 - ST_DEN)) u_dly_anz (
        .clk (clk), .en (en), .d (anz_reg), .q (anz_d)
    );

    ciou_delay #(.WIDTH(25), .DEPTH(ST_TOT - 1 - ST_IOU)) u_dly_iou_tot (
        .clk (clk), .en (en), .d (iou_reg), .q (iou_tot_d)
    );

    ciou_delay #(.WIDTH(28), .DEPTH(ST_TOT - 1 - ST_DIST)) u_dly_dist (
        .clk (clk), .en (en), .d (dist_reg), .q (dist_tot_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tot_reg <= $signed({4'b0, iou_tot_d}) - $signed({1'b0, dist_tot_d})
                     - $signed({4'b0, (anz_d ? q_asp : '0)});
            ovl_reg <= iou_tot_d[24:9];
        end
    end

    assign tot_sh = $signed(tot_reg[28:10]);

    always_comb
    begin
        if (tot_sh > 19'sd32767)
        begin
            cplx_next = 16'sh7FFF;
        end
        else if (tot_sh < -19'sd32768)
        begin
            cplx_next = 16'sh8000;
        end
        else
        begin
            cplx_next = tot_sh[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.overlap_ratio  <= ovl_reg;
            out_reg.complete_ratio <= cplx_next;
        end
    end

    assign ratios = out_reg;

endmodule

[sv/box_ciou.sv]
// IoU and complete IoU of a predicted and a target box.
//
// Input channel: a box pair (corners, signed Q12.4) is one transaction,
// taken at a rising edge with push high and full low. Output channel: the
// oldest result sits on ratios while empty is low and leaves at an edge
// with pop high. overlap_ratio is unsigned Q1.15, complete_ratio is
// signed Q2.14 and saturated.
//
// Throughput: one transaction per cycle, sustained while pop does not hold
// the pipeline. The path from accept to a visible result runs through the
// 25-stage IoU divider feeding the aspect divider, or through the CORDIC
// chain when it is longer.
//
// A front stage takes each pair and forms widths, overlaps and centre
// offsets into a four-entry queue; the back pipeline pulls from it.
// When pop stays low the back pipeline freezes, the queue fills, and
// full rises once the front stage also holds a pair.
// Reset empties the queue and the pipeline; no clearing pass is needed.
module box_ciou #(
    parameter int CORDIC_STEPS = ciou_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  ciou_pkg::ciou_in_t  boxes,
    output logic                empty,
    input  logic                pop,
    output ciou_pkg::ciou_out_t ratios
);
    import ciou_pkg::*;

    logic        fwd_valid;
    ciou_geom_t  fwd_geom;
    ciou_geom_t  head;
    ciou_qstat_t q_stat;
    logic        take;

    ciou_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .boxes     (boxes),
        .q_stat    (q_stat),
        .fwd_valid (fwd_valid),
        .fwd_geom  (fwd_geom)
    );

    ciou_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fwd_valid),
        .wr_data (fwd_geom),
        .rd_en   (take),
        .rd_data (head),
        .stat    (q_stat)
    );

    ciou_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head),
        .take   (take),
        .empty  (empty),
        .pop    (pop),
        .ratios (ratios)
    );

endmodule

[sv/ciou_checker.sv]
module ciou_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input ciou_pkg::ciou_out_t ratios
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    a_iou_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ratios.overlap_ratio <= 16'd32768)
        else $error("overlap ratio above one");

    a_ciou_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> $signed(ratios.complete_ratio) <= $signed({1'b0, ratios.overlap_ratio[15:1]}))
        else $error("complete ratio exceeds overlap ratio");

    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an incoming transaction");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(ratios))
        else $error("stalled result changed");

endmodule

bind box_ciou ciou_checker u_ciou_checker (.*);

[test/box_ciou_tb.sv]
module box_ciou_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ciou_pkg::*;

    localparam int STEPS = 16;
    localparam int RANDOM_PAIRS = 1430;

    // atan(2^-i) in Q30, truncated
    localparam longint ANGLE_Q30 [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic longint lmin(longint a, longint b);
        return a < b ? a : b;
    endfunction

    function automatic longint slope_angle(longint num, longint den);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = den * 16384;
        y = num * 16384;
        z = 0;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += ANGLE_Q30[i];
            end
            else
            begin
                x -= ys; y += xs; z -= ANGLE_Q30[i];
            end
        end
        return z;
    endfunction

    function automatic ciou_out_t box_ratios(ciou_in_t b);
        longint px1, py1, px2, py2, tx1, ty1, tx2, ty2;
        longint iw, ih, dx, dy, cw, ch, pw, ph, tw, th, diff, iou;
        longint dist_term, aspect, ciou, v;
        longint unsigned inter, area_p, area_t, uni, s, c2, ad, sq;
        ciou_out_t r;
        px1 = b.pred_x1; py1 = b.pred_y1; px2 = b.pred_x2; py2 = b.pred_y2;
        tx1 = b.tgt_x1; ty1 = b.tgt_y1; tx2 = b.tgt_x2; ty2 = b.tgt_y2;
        iw = lmax(lmin(px2, tx2) - lmax(px1, tx1), 0);
        ih = lmax(lmin(py2, ty2) - lmax(py1, ty1), 0);
        inter = iw * ih;
        area_p = lmax(px2 - px1, 0) * lmax(py2 - py1, 0);
        area_t = lmax(tx2 - tx1, 0) * lmax(ty2 - ty1, 0);
        uni = area_p + area_t - inter;
        iou = 0;
        if (uni != 0)
            iou = longint'((inter << 24) / uni);
        dx = (px1 + px2) - (tx1 + tx2);
        dy = (py1 + py2) - (ty1 + ty2);
        s = dx * dx + dy * dy;
        cw = lmax(px2, tx2) - lmin(px1, tx1);
        ch = lmax(py2, ty2) - lmin(py1, ty1);
        c2 = cw * cw + ch * ch;
        dist_term = 0;
        if (c2 != 0)
        begin
            if (s >= 32 * c2)
                dist_term = 8 * (64'd1 << 24);
            else
                dist_term = longint'((s << 22) / c2);
        end
        pw = lmax(px2 - px1, 1); ph = lmax(py2 - py1, 1);
        tw = lmax(tx2 - tx1, 1); th = lmax(ty2 - ty1, 1);
        diff = slope_angle(tw, th) - slope_angle(pw, ph);
        ad = diff < 0 ? -diff : diff;
        sq = (ad * ad) >> 36;
        v = longint'((sq * 64'd435171170) >> 30);
        aspect = 0;
        if (v > 0)
            aspect = longint'((longint'(v) * longint'(v)) / (v - iou + (64'd1 << 24)));
        ciou = floor_shift(iou - dist_term - aspect, 10);
        if (ciou > 32767) ciou = 32767;
        if (ciou < -32768) ciou = -32768;
        r.overlap_ratio = 16'(iou >>> 9);
        r.complete_ratio = 16'(ciou);
        return r;
    endfunction

    class ratio_board;
        ciou_out_t pending[$];
        int errors;
        int mismatches;

        function void note_pair(ciou_in_t b);
            pending.insert(pending.size(), box_ratios(b));
        endfunction

        function void check_result(ciou_out_t got);
            ciou_out_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.overlap_ratio !== want.overlap_ratio ||
                got.complete_ratio !== want.complete_ratio)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: iou exp %0d got %0d, ciou exp %0d got %0d",
                             want.overlap_ratio, got.overlap_ratio,
                             want.complete_ratio, got.complete_ratio);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    ciou_in_t boxes = '0;
    ciou_out_t ratios;

    ratio_board board = new();
    ciou_in_t stimulus[$];
    bit feeding_done = 1'b0;
    bit hold_off = 1'b0;

    box_ciou #(.CORDIC_STEPS(STEPS)) u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .boxes(boxes),
        .empty(empty), .pop(pop), .ratios(ratios)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($signed($urandom_range(0, 800)) - 400);
        endcase
    endfunction

    function automatic ciou_in_t rand_pair();
        ciou_in_t b;
        logic signed [15:0] w, h;
        b.pred_x1 = rand_coord(); b.pred_y1 = rand_coord();
        b.tgt_x1 = rand_coord(); b.tgt_y1 = rand_coord();
        if ($urandom_range(0, 3) == 0)
        begin
            b.pred_x2 = rand_coord(); b.pred_y2 = rand_coord();
            b.tgt_x2 = rand_coord(); b.tgt_y2 = rand_coord();
        end
        else
        begin
            // mostly well-formed, overlapping boxes
            b.pred_x1 = 16'($signed($urandom_range(0, 400)) - 200);
            b.pred_y1 = 16'($signed($urandom_range(0, 400)) - 200);
            w = 16'($urandom_range(0, 300)); h = 16'($urandom_range(0, 300));
            b.pred_x2 = b.pred_x1 + w; b.pred_y2 = b.pred_y1 + h;
            b.tgt_x1 = b.pred_x1 + 16'($signed($urandom_range(0, 100)) - 50);
            b.tgt_y1 = b.pred_y1 + 16'($signed($urandom_range(0, 100)) - 50);
            b.tgt_x2 = b.tgt_x1 + 16'($urandom_range(0, 300));
            b.tgt_y2 = b.tgt_y1 + 16'($urandom_range(0, 300));
        end
        return b;
    endfunction

    task automatic add_pair(int a, int b, int c, int d, int e, int f, int g, int h);
        ciou_in_t item;
        item = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h)};
        stimulus.insert(stimulus.size(), item);
    endtask

    task automatic send_pairs();
        int burst;
        ciou_in_t item;
        while (stimulus.size() > 0)
        begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && stimulus.size() > 0)
            begin
                item = stimulus.pop_front();
                push <= 1'b1;
                boxes <= item;
                @(posedge clk);
                while (full)
                    @(posedge clk);
                board.note_pair(item);
                burst--;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        push <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        add_pair(0, 0, 16, 16, 0, 0, 16, 16);             // identical boxes
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);                 // zero union, zero diagonal
        add_pair(10, 10, 0, 0, 20, 20, 5, 5);             // inverted boxes
        add_pair(0, 0, 0, 100, 0, 0, 100, 0);             // thin boxes
        add_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        add_pair(-32768, -32768, -32760, -32760, 32760, 32760, 32767, 32767);
        add_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
        add_pair(0, 0, 100, 10, 0, 0, 10, 100);           // opposite aspect
        add_pair(0, 0, 10, 10, 100, 100, 110, 110);       // far apart
        add_pair(0, 0, 100, 100, 25, 25, 75, 75);         // nested
        add_pair(-50, -20, 30, 40, -10, -30, 60, 10);
        add_pair(0, 0, 1, 1, 0, 0, 1, 1);
        add_pair(0, 0, 32767, 1, 0, 0, 1, 32767);
        for (int i = 0; i < RANDOM_PAIRS; i++)
            stimulus.insert(stimulus.size(), rand_pair());
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_pairs();
        feeding_done = 1'b1;
    end

    // long receiver hold-off so the block fills and backs up its input
    initial
    begin
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        int phase;
        phase = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!empty && pop)
                board.check_result(ratios);
            phase++;
            if (hold_off)
                pop <= 1'b0;
            else if ((phase / 200) % 3 == 0)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        wait (feeding_done);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0)
            $display("box_ciou_tb: done, clean");
        else
            $display("box_ciou_tb: done, errors");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("box_ciou_tb: done, errors");
        $finish;
    end
endmodule

[sim.f]
sv/ciou_pkg.sv
sv/ciou_front.sv
sv/ciou_queue.sv
sv/ciou_delay.sv
sv/ciou_div.sv
sv/ciou_cordic.sv
sv/ciou_back.sv
sv/box_ciou.sv
sv/ciou_checker.sv
test/box_ciou_tb.sv
